// File: hw/rtl/bmp_pkg.sv
// shared types and constants for the binomial coefficient block
`default_nettype none

package bmp_pkg;

  localparam int unsigned TOTAL_W = 20;
  localparam int unsigned COEF_W  = 30;

  localparam logic [29:0] PRIME     = 30'd1000000007;
  // fermat exponent p-2
  localparam logic [29:0] PRIME_EXP = PRIME - 30'd2;
  localparam int unsigned EXP_BITS  = 30;
  localparam int unsigned EXP_CNT_W = $clog2(EXP_BITS + 1);

  // barrett constant floor(2^60 / p), fits in 31 bits
  localparam logic [63:0] BARRETT_MU64 = (64'd1 << 60) / 64'(PRIME);
  localparam logic [30:0] BARRETT_MU   = BARRETT_MU64[30:0];

  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic [TOTAL_W-1:0] chosen;
  } bmp_in_t;

  typedef struct packed {
    logic [COEF_W-1:0] coefficient;
    logic              bad_choice;
  } bmp_out_t;

  typedef enum logic [2:0] {
    OP_FACT,
    OP_DEN,
    OP_ACC,
    OP_SQ,
    OP_FIN
  } mul_op_e;

  typedef struct packed {
    logic    load;
    logic    mul_start;
    logic    wr;
    logic    out_load;
    mul_op_e op;
  } bmp_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic bad;
    logic i_le_n;
    logic exp_bit;
    logic exp_end;
  } bmp_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/binomial_mod_prime.sv
// top level: C(n,k) mod 1000000007 via factorial products and fermat inverse
//
// in channel: in_valid_i / in_stall_o with in_data_i {total, chosen}; a transfer
// happens on a clock edge with valid high and stall low. only the low N_BITS bits
// of each field are used. out channel: out_valid_o / out_stall_i with
// out_data_o {coefficient, bad_choice}; one result per input item.
// one item is worked at a time: every step goes through one shared six-stage
// modular multiplier, one multiply at a time. the steps are n factorial
// multiplies, one for the denominator, 30 squarings plus one multiply for each
// of the 15 set exponent bits, one final multiply, then the output load and a
// return to idle, where the next item can be taken. k > n skips the multiplies
// and finishes with coefficient 0 and bad_choice set.
// the result sits in an output register; the next item is taken as soon as the
// result is loaded there, even while the receiver stalls. a finished result
// waits for the output register to free up before it is loaded.
// reset clears the sequencer and the output valid; no clearing pass is needed.
`default_nettype none

module binomial_mod_prime #(
  parameter int unsigned N_BITS = 20
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire bmp_pkg::bmp_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output bmp_pkg::bmp_out_t      out_data_o
);
  import bmp_pkg::*;

  bmp_cmd_t    cmd;
  bmp_status_t status;

  bmp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  bmp_datapath #(
    .N_BITS (N_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

// File: hw/rtl/bmp_mulmod.sv
// six-stage modular multiplier, barrett reduction by the fixed prime
`default_nettype none

module bmp_mulmod (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [29:0] a_i,
  input  wire logic [29:0] b_i,
  output logic             done_o,
  output logic [29:0]      res_o
);
  import bmp_pkg::*;

  localparam logic [32:0] R_BOUND = 33'(3) * 33'(PRIME);

  logic [5:0]  v_q;
  logic [59:0] prod_q;
  logic [61:0] t_q;
  logic [31:0] xlo2_q, xlo3_q;
  logic [31:0] qp_q;
  logic [31:0] r_q;
  logic [31:0] r5_q;
  logic [29:0] res_q;
  logic [31:0] r5_d;
  logic [31:0] res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[4:0], start_i};
    end
  end

  // remainder estimate is at most two primes above the true one
  assign r5_d  = (r_q >= 32'(PRIME)) ? r_q - 32'(PRIME) : r_q;
  assign res_d = (r5_q >= 32'(PRIME)) ? r5_q - 32'(PRIME) : r5_q;

  always_ff @(posedge clk_i) begin
    prod_q <= 60'(a_i) * 60'(b_i);
    t_q    <= 62'(prod_q[59:29]) * 62'(BARRETT_MU);
    xlo2_q <= prod_q[31:0];
    qp_q   <= 32'(t_q[61:31]) * 32'(PRIME);
    xlo3_q <= xlo2_q;
    r_q    <= xlo3_q - qp_q;
    r5_q   <= r5_d;
    res_q  <= res_d[29:0];
  end

  assign done_o = v_q[5];
  assign res_o  = res_q;

  a_res_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[5] |-> (res_q < PRIME))
    else $error("mulmod result not reduced");

  a_barrett_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[3] |-> (33'(r_q) < R_BOUND))
    else $error("barrett estimate off by more than two");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> (v_q == 6'd0))
    else $error("mulmod started while busy");

endmodule

`default_nettype wire

// File: hw/rtl/bmp_datapath.sv
// datapath: operand registers, counters, shared multiplier and output register
`default_nettype none

module bmp_datapath #(
  parameter int unsigned N_BITS = 20
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire bmp_pkg::bmp_in_t   in_data_i,
  input  wire bmp_pkg::bmp_cmd_t  cmd_i,
  output bmp_pkg::bmp_status_t    status_o,
  output bmp_pkg::bmp_out_t       out_data_o
);
  import bmp_pkg::*;

  localparam int unsigned IW = N_BITS + 1;

  logic [31:0]          tot_ext, cho_ext;
  logic [N_BITS-1:0]    n_q, k_q, nk_q;
  logic                 bad_q;
  logic [IW-1:0]        i_q;
  logic [29:0]          fact_q, fk_q, fnk_q, acc_q, sq_q, res_q;
  logic [EXP_CNT_W-1:0] bit_q;
  bmp_out_t             out_q;
  logic [29:0]          mul_a, mul_b, mul_res;
  logic                 mul_done;

  assign tot_ext = 32'(in_data_i.total);
  assign cho_ext = 32'(in_data_i.chosen);

  always_comb begin
    mul_a = fact_q;
    mul_b = 30'(i_q);
    case (cmd_i.op)
      OP_FACT: begin
        mul_a = fact_q;
        mul_b = 30'(i_q);
      end
      OP_DEN: begin
        mul_a = fk_q;
        mul_b = fnk_q;
      end
      OP_ACC: begin
        mul_a = acc_q;
        mul_b = sq_q;
      end
      OP_SQ: begin
        mul_a = sq_q;
        mul_b = sq_q;
      end
      OP_FIN: begin
        mul_a = fact_q;
        mul_b = acc_q;
      end
      default: begin
        mul_a = fact_q;
        mul_b = 30'(i_q);
      end
    endcase
  end

  bmp_mulmod u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q    <= tot_ext[N_BITS-1:0];
      k_q    <= cho_ext[N_BITS-1:0];
      nk_q   <= tot_ext[N_BITS-1:0] - cho_ext[N_BITS-1:0];
      bad_q  <= cho_ext[N_BITS-1:0] > tot_ext[N_BITS-1:0];
      i_q    <= IW'(1);
      fact_q <= 30'd1;
      fk_q   <= 30'd1;
      fnk_q  <= 30'd1;
      res_q  <= '0;
    end else if (cmd_i.wr) begin
      case (cmd_i.op)
        OP_FACT: begin
          fact_q <= mul_res;
          if (i_q == {1'b0, k_q}) begin
            fk_q <= mul_res;
          end
          if (i_q == {1'b0, nk_q}) begin
            fnk_q <= mul_res;
          end
          i_q <= i_q + IW'(1);
        end
        OP_DEN: begin
          sq_q  <= mul_res;
          acc_q <= 30'd1;
          bit_q <= '0;
        end
        OP_ACC: begin
          acc_q <= mul_res;
        end
        OP_SQ: begin
          sq_q  <= mul_res;
          bit_q <= bit_q + EXP_CNT_W'(1);
        end
        OP_FIN: begin
          res_q <= mul_res;
        end
        default: begin
          res_q <= res_q;
        end
      endcase
    end
    if (cmd_i.out_load) begin
      out_q.coefficient <= res_q;
      out_q.bad_choice  <= bad_q;
    end
  end

  assign status_o.mul_done = mul_done;
  assign status_o.bad      = bad_q;
  assign status_o.i_le_n   = i_q <= {1'b0, n_q};
  assign status_o.exp_end  = bit_q == EXP_CNT_W'(EXP_BITS);
  assign status_o.exp_bit  = (bit_q != EXP_CNT_W'(EXP_BITS)) && PRIME_EXP[bit_q];

  assign out_data_o = out_q;

endmodule

`default_nettype wire

// File: hw/rtl/bmp_ctrl.sv
// controller: sequences factorial loop, exponentiation and result transfer
`default_nettype none

module bmp_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  input  wire bmp_pkg::bmp_status_t status_i,
  output bmp_pkg::bmp_cmd_t         cmd_o
);
  import bmp_pkg::*;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_FACT_GO   = 4'd1;
  localparam logic [3:0] S_FACT_WAIT = 4'd2;
  localparam logic [3:0] S_DEN_WAIT  = 4'd3;
  localparam logic [3:0] S_POW_GO    = 4'd4;
  localparam logic [3:0] S_ACC_WAIT  = 4'd5;
  localparam logic [3:0] S_SQ_GO     = 4'd6;
  localparam logic [3:0] S_SQ_WAIT   = 4'd7;
  localparam logic [3:0] S_FIN_WAIT  = 4'd8;
  localparam logic [3:0] S_OUT       = 4'd9;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d       = state_q;
    cmd_o.load      = 1'b0;
    cmd_o.mul_start = 1'b0;
    cmd_o.wr        = 1'b0;
    cmd_o.out_load  = 1'b0;
    cmd_o.op        = OP_FACT;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_FACT_GO;
        end
      end
      S_FACT_GO: begin
        if (status_i.bad) begin
          state_d = S_OUT;
        end else if (status_i.i_le_n) begin
          cmd_o.op        = OP_FACT;
          cmd_o.mul_start = 1'b1;
          state_d         = S_FACT_WAIT;
        end else begin
          cmd_o.op        = OP_DEN;
          cmd_o.mul_start = 1'b1;
          state_d         = S_DEN_WAIT;
        end
      end
      S_FACT_WAIT: begin
        cmd_o.op = OP_FACT;
        if (status_i.mul_done) begin
          cmd_o.wr = 1'b1;
          state_d  = S_FACT_GO;
        end
      end
      S_DEN_WAIT: begin
        cmd_o.op = OP_DEN;
        if (status_i.mul_done) begin
          cmd_o.wr = 1'b1;
          state_d  = S_POW_GO;
        end
      end
      S_POW_GO: begin
        cmd_o.mul_start = 1'b1;
        if (status_i.exp_end) begin
          cmd_o.op = OP_FIN;
          state_d  = S_FIN_WAIT;
        end else if (status_i.exp_bit) begin
          cmd_o.op = OP_ACC;
          state_d  = S_ACC_WAIT;
        end else begin
          cmd_o.op = OP_SQ;
          state_d  = S_SQ_WAIT;
        end
      end
      S_ACC_WAIT: begin
        cmd_o.op = OP_ACC;
        if (status_i.mul_done) begin
          cmd_o.wr = 1'b1;
          state_d  = S_SQ_GO;
        end
      end
      S_SQ_GO: begin
        cmd_o.op        = OP_SQ;
        cmd_o.mul_start = 1'b1;
        state_d         = S_SQ_WAIT;
      end
      S_SQ_WAIT: begin
        cmd_o.op = OP_SQ;
        if (status_i.mul_done) begin
          cmd_o.wr = 1'b1;
          state_d  = S_POW_GO;
        end
      end
      S_FIN_WAIT: begin
        cmd_o.op = OP_FIN;
        if (status_i.mul_done) begin
          cmd_o.wr = 1'b1;
          state_d  = S_OUT;
        end
      end
      S_OUT: begin
        // hold the result until the output register frees up
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.mul_done |-> (state_q == S_FACT_WAIT || state_q == S_DEN_WAIT ||
                           state_q == S_ACC_WAIT || state_q == S_SQ_WAIT ||
                           state_q == S_FIN_WAIT))
    else $error("multiplier finished outside a wait state");

  a_out_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("output register overwritten before transfer");

  a_bad_skips_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FACT_GO && status_i.bad) |=> (state_q == S_OUT))
    else $error("bad choice did not go straight to output");

endmodule

`default_nettype wire
